// File: rtl/density_clustering_top_assert.svh
// assertion macros for the density clustering block
// used by density_clustering_top; expects clk_i and rst_ni in scope
`ifndef DENSITY_CLUSTERING_TOP_ASSERT_SVH
`define DENSITY_CLUSTERING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DBC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("density_clustering: assertion failed");
`define DBC_NEVER(lbl, expr) `DBC_ASSERT(lbl, !(expr))
`else
`define DBC_ASSERT(lbl, prop)
`define DBC_NEVER(lbl, expr)
`endif
`endif

// File: rtl/dbc_pkg.sv
// shared constants, types and helpers of the density clustering block
// no dependencies
`default_nettype none
package dbc_pkg;
  localparam int MAX_POINTS = 32;
  localparam int MAX_DIMS   = 4;
  localparam int COORD_W    = 16;

  localparam int PT_W      = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DIMS_W    = 3;
  localparam int ADDR_W    = PT_W + DIM_W;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int SUM_W     = SQ_W + $clog2(MAX_DIMS + 1);
  localparam int RADIUS_W  = 32;
  localparam int LIMIT_W   = 2 * RADIUS_W;
  localparam int MINPTS_W  = 6;
  localparam int MEASURE_W = 2;
  localparam int CID_W     = 6;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // distance measure codes, code three behaves as euclidean
  localparam logic [MEASURE_W-1:0] MEAS_EUCLID    = 2'd0;
  localparam logic [MEASURE_W-1:0] MEAS_RMS       = 2'd1;
  localparam logic [MEASURE_W-1:0] MEAS_MANHATTAN = 2'd2;

  // register indexes
  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_MINPTS   = 2'd1;
  localparam logic [1:0] REG_MEASURE  = 2'd2;
  localparam logic [1:0] REG_DIMS     = 2'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RST  = 32'd256;
  localparam logic [MINPTS_W-1:0] MINPTS_RST  = 6'd4;
  localparam logic [DIMS_W-1:0]   DIMS_RST    = 3'd2;

  typedef struct packed {
    logic clear;
    logic p_next;
    logic p_begin;
    logic dist_start;
    logic cnt_step;
    logic new_cluster;
    logic scan_step;
    logic expand;
    logic cluster_end;
    logic q_pop;
    logic q_load;
    logic q_visit;
    logic q_assign;
    logic o_start;
    logic o_next;
    logic finish;
  } dbc_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic p_done;
    logic p_skip;
    logic i_last;
    logic dist_done;
    logic dist_busy;
    logic core;
    logic q_empty;
    logic c_visited;
  } dbc_stat_t;

  typedef struct packed {
    logic [PT_W-1:0]  point_index;
    logic [CID_W-1:0] cluster_id;
    logic             is_seed;
    logic [CID_W-1:0] cluster_size;
    logic             final_res;
  } dbc_res_t;

  // coordinates in use: zero counts as one, large values saturate
  function automatic logic [DIMS_W-1:0] dims_in_use(input logic [DIMS_W-1:0] d);
    logic [DIMS_W-1:0] r;
    r = d;
    if (d == '0) r = DIMS_W'(1);
    else if (d > DIMS_W'(MAX_DIMS)) r = DIMS_W'(MAX_DIMS);
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/dbc_if.sv
// valid/ready channel interfaces for coordinate input and result output
// depends on dbc_pkg
`default_nettype none
interface dbc_in_if;
  import dbc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord;
  logic                      last;
  modport source (output valid, coord, last, input ready);
  modport sink (input valid, coord, last, output ready);
endinterface

interface dbc_out_if;
  import dbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PT_W-1:0]  point_index;
  logic [CID_W-1:0] cluster_id;
  logic             is_seed;
  logic [CID_W-1:0] cluster_size;
  logic             final_res;
  modport source (output valid, point_index, cluster_id, is_seed, cluster_size, final_res,
                  input ready);
  modport sink (input valid, point_index, cluster_id, is_seed, cluster_size, final_res,
                output ready);
endinterface
`default_nettype wire

// File: rtl/dbc_dist.sv
// pair distance unit: coordinate memory and per-dimension accumulate pipeline
// depends on dbc_pkg
`default_nettype none
module dbc_dist (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [dbc_pkg::ADDR_W-1:0]         wr_addr_i,
  input  logic signed [dbc_pkg::COORD_W-1:0] wr_data_i,
  input  logic                               start_i,
  input  logic [dbc_pkg::PT_W-1:0]           a_i,
  input  logic [dbc_pkg::PT_W-1:0]           b_i,
  input  logic [dbc_pkg::DIMS_W-1:0]         dims_i,
  input  logic [dbc_pkg::MEASURE_W-1:0]      measure_i,
  input  logic [dbc_pkg::RADIUS_W-1:0]       radius_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic                               near_o
);
  import dbc_pkg::*;

  logic signed [COORD_W-1:0] mem [2**ADDR_W];
  logic signed [COORD_W-1:0] rd_a_q, rd_b_q;
  logic [PT_W-1:0]    a_q, b_q;
  logic [DIMS_W-1:0]  iss_q;
  logic               busy_q, v1_q, v2_q, v3_q;
  logic [COORD_W-1:0] mag_q;
  logic [SQ_W-1:0]    term_q;
  logic [SUM_W-1:0]   sum_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               issue;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]   mag_full;
  logic [LIMIT_W-1:0] limit_d;

  assign issue = busy_q && (iss_q < dims_i);
  assign done_o = busy_q && !issue && !v1_q && !v2_q && !v3_q;
  assign busy_o = busy_q;
  assign near_o = LIMIT_W'(sum_q) < limit_q;

  // coordinate memory, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_a_q <= mem[{a_q, iss_q[DIM_W-1:0]}];
    rd_b_q <= mem[{b_q, iss_q[DIM_W-1:0]}];
  end

  // absolute difference
  assign diff = {rd_a_q[COORD_W-1], rd_a_q} - {rd_b_q[COORD_W-1], rd_b_q};
  assign mag_full = diff[COORD_W] ? (~diff + 1'b1) : diff;

  // threshold: radius for rms and manhattan, radius squared otherwise
  always_comb begin
    if (measure_i == MEAS_RMS || measure_i == MEAS_MANHATTAN) limit_d = LIMIT_W'(radius_i);
    else limit_d = LIMIT_W'(radius_i) * LIMIT_W'(radius_i);
  end

  // operands and pipeline payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= a_i;
      b_q     <= b_i;
      limit_q <= limit_d;
    end
    if (v1_q) mag_q <= mag_full[COORD_W-1:0];
    if (v2_q) begin
      if (measure_i == MEAS_MANHATTAN) term_q <= SQ_W'(mag_q);
      else term_q <= SQ_W'(mag_q) * SQ_W'(mag_q);
    end
  end

  // issue control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iss_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      sum_q  <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (start_i) begin
        busy_q <= 1'b1;
        iss_q  <= '0;
        sum_q  <= '0;
      end else begin
        if (issue) iss_q <= iss_q + 1'b1;
        if (v3_q) sum_q <= sum_q + SUM_W'(term_q);
        if (done_o) busy_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/dbc_dpath.sv
// clustering datapath: loader, point flags, queue, cluster memories, result word
// depends on dbc_pkg and dbc_dist
`default_nettype none
module dbc_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dbc_pkg::dbc_cmd_t                  cmd_i,
  output dbc_pkg::dbc_stat_t                 stat_o,
  input  logic                               load_i,
  input  logic signed [dbc_pkg::COORD_W-1:0] coord_i,
  input  logic                               last_i,
  input  logic [dbc_pkg::DIMS_W-1:0]         dims_i,
  input  logic [dbc_pkg::MEASURE_W-1:0]      measure_i,
  input  logic [dbc_pkg::RADIUS_W-1:0]       radius_i,
  input  logic [dbc_pkg::MINPTS_W-1:0]       minpts_i,
  output dbc_pkg::dbc_res_t                  res_o
);
  import dbc_pkg::*;

  logic [CNT_W-1:0] pts_q, p_q, i_q, cnt_q, head_q, tail_q, size_q;
  logic [CID_W-1:0] k_q;
  logic [DIM_W-1:0] dim_q;
  logic [PT_W-1:0]  c_q;
  logic [MAX_POINTS-1:0] visited_q, assigned_q, queued_q, seed_q;
  logic [PT_W-1:0]  queue_mem [MAX_POINTS];
  logic [CID_W-1:0] cid_mem [MAX_POINTS];
  logic [CID_W-1:0] size_mem [MAX_POINTS];
  logic [PT_W-1:0]  q_rd_q;
  logic [CID_W-1:0] cid_rd_q, size_rd_q;
  logic             full, point_end, near, push, cid_we;
  logic [PT_W-1:0]  p_idx, i_idx, cid_addr;
  logic [CID_W-1:0] cid_data;

  assign p_idx = p_q[PT_W-1:0];
  assign i_idx = i_q[PT_W-1:0];
  assign full  = pts_q == CNT_W'(MAX_POINTS);
  assign point_end = (DIMS_W'(dim_q) + DIMS_W'(1)) >= dims_i;

  dbc_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_i && !full),
    .wr_addr_i ({pts_q[PT_W-1:0], dim_q}),
    .wr_data_i (coord_i),
    .start_i   (cmd_i.dist_start),
    .a_i       (c_q),
    .b_i       (i_idx),
    .dims_i    (dims_i),
    .measure_i (measure_i),
    .radius_i  (radius_i),
    .busy_o    (stat_o.dist_busy),
    .done_o    (stat_o.dist_done),
    .near_o    (near)
  );

  // status toward the controller
  assign stat_o.n_zero    = pts_q == '0;
  assign stat_o.p_done    = p_q == pts_q;
  assign stat_o.p_skip    = visited_q[p_idx] || assigned_q[p_idx];
  assign stat_o.i_last    = (i_q + 1'b1) == pts_q;
  assign stat_o.core      = cnt_q >= CNT_W'(minpts_i);
  assign stat_o.q_empty   = head_q == tail_q;
  assign stat_o.c_visited = visited_q[c_q];

  // queue push: seed scan takes every neighbour, expansion only fresh points
  assign push = cmd_i.scan_step && near &&
                (!cmd_i.expand || (!assigned_q[i_idx] && !queued_q[i_idx]));

  // cluster id write: seed or newly joined member
  assign cid_we   = cmd_i.new_cluster || (cmd_i.q_assign && !assigned_q[c_q]);
  assign cid_addr = cmd_i.new_cluster ? p_idx : c_q;
  assign cid_data = cmd_i.new_cluster ? k_q + 1'b1 : k_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (push) queue_mem[tail_q[PT_W-1:0]] <= i_idx;
    if (cid_we) cid_mem[cid_addr] <= cid_data;
    if (cmd_i.cluster_end) size_mem[p_idx] <= size_q;
    q_rd_q    <= queue_mem[head_q[PT_W-1:0]];
    cid_rd_q  <= cid_mem[i_idx];
    size_rd_q <= size_mem[i_idx];
  end

  // current point under test
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_begin) c_q <= p_idx;
    else if (cmd_i.q_load) c_q <= q_rd_q;
  end

  // loader and clustering counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q      <= '0;
      dim_q      <= '0;
      p_q        <= '0;
      i_q        <= '0;
      cnt_q      <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      size_q     <= '0;
      k_q        <= '0;
      visited_q  <= '0;
      assigned_q <= '0;
      queued_q   <= '0;
      seed_q     <= '0;
    end else begin
      if (load_i) begin
        if (point_end || last_i) dim_q <= '0;
        else dim_q <= dim_q + 1'b1;
        if (point_end && !full) pts_q <= pts_q + 1'b1;
      end
      if (cmd_i.finish) begin
        pts_q <= '0;
        dim_q <= '0;
      end
      if (cmd_i.clear) begin
        visited_q  <= '0;
        assigned_q <= '0;
        seed_q     <= '0;
        k_q        <= '0;
        p_q        <= '0;
      end
      if (cmd_i.p_next || cmd_i.cluster_end) p_q <= p_q + 1'b1;
      if (cmd_i.p_begin) begin
        visited_q[p_idx] <= 1'b1;
        i_q   <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.q_visit) begin
        visited_q[c_q] <= 1'b1;
        i_q   <= '0;
        cnt_q <= '0;
      end
      // count pass ends with the index back at zero for the gather scan
      if (cmd_i.cnt_step) begin
        i_q <= stat_o.i_last ? '0 : i_q + 1'b1;
        if (near) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.new_cluster) begin
        k_q               <= k_q + 1'b1;
        assigned_q[p_idx] <= 1'b1;
        seed_q[p_idx]     <= 1'b1;
        queued_q          <= '0;
        head_q            <= '0;
        tail_q            <= '0;
        size_q            <= CNT_W'(1);
        i_q               <= '0;
      end
      if (cmd_i.scan_step) i_q <= i_q + 1'b1;
      if (push) begin
        queued_q[i_idx] <= 1'b1;
        tail_q          <= tail_q + 1'b1;
      end
      if (cmd_i.q_pop) head_q <= head_q + 1'b1;
      if (cmd_i.q_assign && !assigned_q[c_q]) begin
        assigned_q[c_q] <= 1'b1;
        size_q          <= size_q + 1'b1;
      end
      if (cmd_i.o_start) i_q <= '0;
      if (cmd_i.o_next) i_q <= i_q + 1'b1;
    end
  end

  // result word for point i
  assign res_o.point_index  = i_idx;
  assign res_o.cluster_id   = assigned_q[i_idx] ? cid_rd_q : '0;
  assign res_o.is_seed      = seed_q[i_idx];
  assign res_o.cluster_size = seed_q[i_idx] ? size_rd_q : '0;
  assign res_o.final_res    = stat_o.i_last;
endmodule
`default_nettype wire

// File: rtl/dbc_ctrl.sv
// clustering controller: load, per-point visit, queue expansion, result output
// depends on dbc_pkg
`default_nettype none
module dbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dbc_pkg::dbc_stat_t stat_i,
  output dbc_pkg::dbc_cmd_t  cmd_o
);
  import dbc_pkg::*;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_START = 14'b00000000000010,
    S_PTEST = 14'b00000000000100,
    S_CGO   = 14'b00000000001000,
    S_CWAIT = 14'b00000000010000,
    S_CEND  = 14'b00000000100000,
    S_SGO   = 14'b00000001000000,
    S_SWAIT = 14'b00000010000000,
    S_QTEST = 14'b00000100000000,
    S_QLOAD = 14'b00001000000000,
    S_QVIS  = 14'b00010000000000,
    S_QASGN = 14'b00100000000000,
    S_ORD   = 14'b01000000000000,
    S_OSEND = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   expand_q, expand_d;

  assign in_ready_o  = state_q == S_LOAD;
  assign out_valid_o = state_q == S_OSEND;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    expand_d = expand_q;
    cmd_o    = '0;
    cmd_o.expand = expand_q;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_last_i) state_d = S_START;
      end
      S_START: begin
        if (stat_i.n_zero) begin
          cmd_o.finish = 1'b1;
          state_d = S_LOAD;
        end else begin
          cmd_o.clear = 1'b1;
          state_d = S_PTEST;
        end
      end
      S_PTEST: begin
        if (stat_i.p_done) begin
          cmd_o.o_start = 1'b1;
          state_d = S_ORD;
        end else if (stat_i.p_skip) begin
          cmd_o.p_next = 1'b1;
        end else begin
          cmd_o.p_begin = 1'b1;
          expand_d = 1'b0;
          state_d = S_CGO;
        end
      end
      S_CGO: begin
        cmd_o.dist_start = 1'b1;
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        if (stat_i.dist_done) begin
          cmd_o.cnt_step = 1'b1;
          state_d = stat_i.i_last ? S_CEND : S_CGO;
        end
      end
      S_CEND: begin
        if (!expand_q) begin
          if (stat_i.core) begin
            cmd_o.new_cluster = 1'b1;
            state_d = S_SGO;
          end else begin
            cmd_o.p_next = 1'b1;
            state_d = S_PTEST;
          end
        end else if (stat_i.core) begin
          state_d = S_SGO;
        end else begin
          state_d = S_QASGN;
        end
      end
      S_SGO: begin
        cmd_o.dist_start = 1'b1;
        state_d = S_SWAIT;
      end
      S_SWAIT: begin
        if (stat_i.dist_done) begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.i_last) state_d = expand_q ? S_QASGN : S_QTEST;
          else state_d = S_SGO;
        end
      end
      S_QTEST: begin
        if (stat_i.q_empty) begin
          cmd_o.cluster_end = 1'b1;
          state_d = S_PTEST;
        end else begin
          cmd_o.q_pop = 1'b1;
          state_d = S_QLOAD;
        end
      end
      S_QLOAD: begin
        cmd_o.q_load = 1'b1;
        state_d = S_QVIS;
      end
      S_QVIS: begin
        if (stat_i.c_visited) begin
          state_d = S_QASGN;
        end else begin
          cmd_o.q_visit = 1'b1;
          expand_d = 1'b1;
          state_d = S_CGO;
        end
      end
      S_QASGN: begin
        cmd_o.q_assign = 1'b1;
        state_d = S_QTEST;
      end
      S_ORD: begin
        state_d = S_OSEND;
      end
      S_OSEND: begin
        if (out_ready_i) begin
          if (stat_i.i_last) begin
            cmd_o.finish = 1'b1;
            state_d = S_LOAD;
          end else begin
            cmd_o.o_next = 1'b1;
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      expand_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      expand_q <= expand_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/density_clustering_top.sv
// DBSCAN clustering over up to 32 loaded points of 1 to 4 signed 16-bit coordinates.
// Coordinates load one word per cycle; the word with last set closes the set and starts
// clustering, during which no word is taken. Each pair distance test runs through the
// coordinate memory's two read ports and a squaring multiplier, one dimension per cycle.
// Every point not yet visited costs n pair tests for its neighbour count, and each core
// point another n tests to gather neighbours, so a set of n points takes roughly
// (n + cores) * n pair tests. One result word per point follows in load order; final_res
// marks the last one.
// depends on dbc_pkg, dbc_if, dbc_ctrl, dbc_dpath and the assertion header
`default_nettype none
`include "density_clustering_top_assert.svh"
module density_clustering_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dbc_in_if.sink                      in_i,
  dbc_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbc_pkg::CFG_AW-1:0]  paddr,
  input  logic [dbc_pkg::CFG_DW-1:0]  pwdata,
  output logic [dbc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import dbc_pkg::*;

  logic [RADIUS_W-1:0]  radius_q;
  logic [MINPTS_W-1:0]  minpts_q;
  logic [MEASURE_W-1:0] measure_q;
  logic [DIMS_W-1:0]    dims_q;
  logic [1:0]           reg_idx;
  logic                 cfg_wr;
  dbc_cmd_t             cmd;
  dbc_stat_t            stat;
  dbc_res_t             res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      minpts_q  <= MINPTS_RST;
      measure_q <= MEAS_EUCLID;
      dims_q    <= DIMS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RADIUS:  radius_q  <= pwdata[RADIUS_W-1:0];
        REG_MINPTS:  minpts_q  <= pwdata[MINPTS_W-1:0];
        REG_MEASURE: measure_q <= pwdata[MEASURE_W-1:0];
        REG_DIMS:    dims_q    <= pwdata[DIMS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_RADIUS:  prdata = CFG_DW'(radius_q);
      REG_MINPTS:  prdata = CFG_DW'(minpts_q);
      REG_MEASURE: prdata = CFG_DW'(measure_q);
      REG_DIMS:    prdata = CFG_DW'(dims_q);
      default:     prdata = '0;
    endcase
  end

  dbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dbc_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .load_i    (in_i.valid && in_i.ready),
    .coord_i   (in_i.coord),
    .last_i    (in_i.last),
    .dims_i    (dims_in_use(dims_q)),
    .measure_i (measure_q),
    .radius_i  (radius_q),
    .minpts_i  (minpts_q),
    .res_o     (res)
  );

  // result word
  assign out_o.point_index  = res.point_index;
  assign out_o.cluster_id   = res.cluster_id;
  assign out_o.is_seed      = res.is_seed;
  assign out_o.cluster_size = res.cluster_size;
  assign out_o.final_res    = res.final_res;

  // checks
  `DBC_NEVER(a_load_out_excl, in_i.ready && out_o.valid)
  `DBC_ASSERT(a_last_stops_load, (in_i.valid && in_i.ready && in_i.last) |=> !in_i.ready)
  `DBC_ASSERT(a_final_reopens, (out_o.valid && out_o.ready && out_o.final_res) |=> in_i.ready)
  `DBC_NEVER(a_dist_restart, cmd.dist_start && stat.dist_busy)
endmodule
`default_nettype wire

// File: sim/dbc_check.sv
// result checker for the density clustering block: predicts cluster labels per data set
// depends on dbc_pkg and dbc_if; watches the coordinate and result channels
`default_nettype none
module dbc_check (
  input  logic         clk_i,
  input  logic         rst_ni,
  dbc_in_if            in_w,
  dbc_out_if           out_w,
  input  logic [31:0]  radius_i,
  input  logic [5:0]   minpts_i,
  input  logic [1:0]   measure_i,
  input  logic [2:0]   dims_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           sets_o,
  output int           results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  localparam int LAB_DEPTH = 2 * MAX_POINTS;

  logic signed [COORD_W-1:0] coords_q [MAX_POINTS][MAX_DIMS];
  int unsigned               npts_q;
  int unsigned               dimc_q;
  dbc_res_t                  labels_q [LAB_DEPTH];
  int unsigned               lab_wr_q;
  int unsigned               lab_rd_q;

  assign pending_o = int'(lab_wr_q - lab_rd_q);

  function automatic int unsigned dims_eff();
    if (dims_i == 3'd0) return 1;
    if (dims_i > 3'(MAX_DIMS)) return MAX_DIMS;
    return dims_i;
  endfunction

  // strict neighbour test without a root
  function automatic bit near(int unsigned a, int unsigned b, int unsigned d);
    logic [63:0]        acc;
    logic [63:0]        lim;
    longint             diff;
    logic [63:0]        mag;
    acc = '0;
    for (int k = 0; k < d; k++) begin
      diff = longint'(coords_q[a][k]) - longint'(coords_q[b][k]);
      mag  = (diff < 0) ? -diff : diff;
      acc += (measure_i == MEAS_MANHATTAN) ? mag : mag * mag;
    end
    if (measure_i == MEAS_RMS || measure_i == MEAS_MANHATTAN) lim = {32'd0, radius_i};
    else lim = {32'd0, radius_i} * {32'd0, radius_i};
    return acc < lim;
  endfunction

  function automatic int unsigned near_count(int unsigned q, int unsigned n,
                                             int unsigned d);
    int unsigned c;
    c = 0;
    for (int i = 0; i < n; i++) if (near(q, i, d)) c++;
    return c;
  endfunction

  // dbscan over the loaded set, appends one label word per point
  task automatic label_set(int unsigned n, int unsigned d);
    int unsigned cid [MAX_POINTS];
    bit          seen [MAX_POINTS];
    bit          seed [MAX_POINTS];
    bit          inq [MAX_POINTS];
    int unsigned sz [MAX_POINTS];
    int unsigned fq [MAX_POINTS];
    int unsigned nclus, q, csize, head, tail;
    dbc_res_t    r;
    nclus = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      cid[i] = 0; seen[i] = 0; seed[i] = 0; sz[i] = 0;
    end
    for (int p = 0; p < n; p++) begin
      if (cid[p] != 0 || seen[p]) continue;
      seen[p] = 1;
      if (near_count(p, n, d) < minpts_i) continue;
      nclus++;
      cid[p] = nclus; seed[p] = 1; csize = 1;
      head = 0; tail = 0;
      for (int i = 0; i < MAX_POINTS; i++) inq[i] = 0;
      for (int i = 0; i < n; i++)
        if (near(p, i, d)) begin fq[tail] = i; inq[i] = 1; tail++; end
      while (head < tail) begin
        q = fq[head];
        head++;
        if (!seen[q]) begin
          seen[q] = 1;
          if (near_count(q, n, d) >= minpts_i)
            for (int i = 0; i < n; i++)
              if (near(q, i, d) && cid[i] == 0 && !inq[i] && tail < MAX_POINTS) begin
                fq[tail] = i; inq[i] = 1; tail++;
              end
        end
        if (cid[q] == 0) begin cid[q] = nclus; csize++; end
      end
      sz[nclus-1] = csize;
    end
    for (int i = 0; i < n; i++) begin
      r.point_index  = PT_W'(i);
      r.cluster_id   = CID_W'(cid[i]);
      r.is_seed      = seed[i];
      r.cluster_size = seed[i] ? CID_W'(sz[cid[i]-1]) : '0;
      r.final_res    = (i + 1 == n);
      labels_q[lab_wr_q % LAB_DEPTH] = r;
      lab_wr_q++;
    end
  endtask

  // coordinate words build the point set, last word triggers prediction
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned d;
    if (!rst_ni) begin
      npts_q = 0; dimc_q = 0; lab_wr_q = 0;
      sets_o <= 0;
    end else if (in_w.valid && in_w.ready) begin
      d = dims_eff();
      if (npts_q < MAX_POINTS) coords_q[npts_q][dimc_q] = in_w.coord;
      if (dimc_q + 1 >= d) begin
        dimc_q = 0;
        if (npts_q < MAX_POINTS) npts_q++;
      end else dimc_q++;
      if (in_w.last) begin
        label_set(npts_q, d);
        sets_o <= sets_o + 1;
        npts_q = 0; dimc_q = 0;
      end
    end
  end

  // compare each result word with the oldest label
  always @(posedge clk_i or negedge rst_ni) begin
    dbc_res_t want;
    if (!rst_ni) begin
      fail_count_o <= 0; results_o <= 0; lab_rd_q = 0;
    end else if (out_w.valid && out_w.ready) begin
      results_o <= results_o + 1;
      if (lab_wr_q == lab_rd_q) begin
        $display("%0t: unexpected result idx=%0d cid=%0d", $time, out_w.point_index,
                 out_w.cluster_id);
        fail_count_o <= fail_count_o + 1;
      end else begin
        want = labels_q[lab_rd_q % LAB_DEPTH];
        lab_rd_q++;
        if (out_w.point_index !== want.point_index || out_w.cluster_id !== want.cluster_id
            || out_w.is_seed !== want.is_seed || out_w.cluster_size !== want.cluster_size
            || out_w.final_res !== want.final_res) begin
          $display("%0t: mismatch exp idx=%0d cid=%0d seed=%0b size=%0d fin=%0b", $time,
                   want.point_index, want.cluster_id, want.is_seed, want.cluster_size,
                   want.final_res);
          $display("%0t:          got idx=%0d cid=%0d seed=%0b size=%0d fin=%0b", $time,
                   out_w.point_index, out_w.cluster_id, out_w.is_seed,
                   out_w.cluster_size, out_w.final_res);
          fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sim/density_clustering_top_tb.sv
// stimulus top for the density clustering block: config writes, point sets, verdict
// depends on dbc_pkg, dbc_if, density_clustering_top and dbc_check
`default_nettype none
module density_clustering_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic [31:0] radius_r;
  logic [5:0]  minpts_r;
  logic [1:0]  measure_r;
  logic [2:0]  dims_r;
  int fails, pending, sets, results, cycles, words;
  bit hold_rx;

  dbc_in_if  in_w ();
  dbc_out_if out_w ();

  density_clustering_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w.sink), .out_o(out_w.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dbc_check chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_w), .out_w(out_w),
    .radius_i(radius_r), .minpts_i(minpts_r), .measure_i(measure_r), .dims_i(dims_r),
    .fail_count_o(fails), .pending_o(pending), .sets_o(sets), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side stalls, with one long hold-off once results start
  initial begin
    out_w.ready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_w.ready <= 0;
        while (!out_w.valid) @(posedge clk_i);
        repeat (400) @(posedge clk_i);
        hold_rx = 0;
      end
      if ($urandom_range(0, 4) == 0) begin
        out_w.ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_w.ready <= 1;
      end else begin
        out_w.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= CFG_AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    case (idx)
      REG_RADIUS:  radius_r  = val;
      REG_MINPTS:  minpts_r  = val[5:0];
      REG_MEASURE: measure_r = val[1:0];
      default:     dims_r    = val[2:0];
    endcase
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic setup(logic [31:0] rad, logic [5:0] mp, logic [1:0] ms, logic [2:0] dm);
    settle();
    reg_write(REG_RADIUS, rad);
    reg_write(REG_MINPTS, mp);
    reg_write(REG_MEASURE, ms);
    reg_write(REG_DIMS, dm);
  endtask

  // offer one coordinate word, optional random gap first
  task automatic send_word(logic [15:0] c, logic lst, bit gaps);
    int gap;
    gap = 0;
    if (gaps && $urandom_range(0, 2) == 0) gap = $urandom_range(0, 18);
    if (gap > 0) begin
      in_w.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid <= 1; in_w.coord <= c; in_w.last <= lst;
    do @(posedge clk_i); while (!in_w.ready);
    words++;
  endtask

  // random clustered set: most points near a few centres
  task automatic send_set(int npts, int nd, int spread, bit gaps);
    logic [15:0] ctr [4][4];
    int          pick;
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) ctr[c][k] = 16'($urandom);
    for (int p = 0; p < npts; p++) begin
      pick = $urandom_range(0, 3);
      for (int k = 0; k < nd; k++)
        send_word(($urandom_range(0, 9) == 0) ? 16'($urandom)
                  : ctr[pick][k] + 16'($signed($urandom_range(0, 2 * spread)) - spread),
                  (p == npts - 1) && (k == nd - 1), gaps);
    end
    in_w.valid <= 0;
  endtask

  initial begin
    int nd;
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_w.valid = 0; in_w.coord = '0; in_w.last = 0; words = 0; hold_rx = 0;
    radius_r = RADIUS_RST; minpts_r = MINPTS_RST; measure_r = MEAS_EUCLID; dims_r = DIMS_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // directed: reset config, extremes of coordinates, one point set
    send_word(16'h8000, 0, 0); send_word(16'h7fff, 0, 0);
    send_word(16'h7fff, 0, 0); send_word(16'h8000, 0, 0);
    send_word(16'h0000, 0, 0); send_word(16'hffff, 0, 0);
    send_word(16'h0001, 0, 0); send_word(16'h0000, 1, 0);
    in_w.valid <= 0;
    setup(32'd1, 6'd1, MEAS_MANHATTAN, 3'd1);
    send_word(16'h0005, 1, 0);  // single point
    in_w.valid <= 0;
    setup(32'hffffffff, 6'd32, MEAS_RMS, 3'd4);
    for (int i = 0; i < 9; i++) send_word(16'($urandom), i == 8, 0);  // partial point dropped
    in_w.valid <= 0;
    setup(32'd0, 6'd0, 2'd3, 3'd0);  // radius zero, minpts zero, measure three, dims zero
    send_word(16'h1234, 0, 0); send_word(16'h1234, 1, 0);
    in_w.valid <= 0;
    setup(32'd40, 6'd2, MEAS_EUCLID, 3'd7);  // dims saturate, capacity overflow
    hold_rx = 1;
    send_set(36, 4, 20, 0);
    send_set(8, 4, 20, 0);  // offered while the results of the full set are held off
    settle();  // pause until drained

    // random sets over many settings
    while (words < 330) begin
      nd = $urandom_range(1, 4);
      case ($urandom_range(0, 2))
        0: setup($urandom_range(1, 80), $urandom_range(1, 5), MEAS_EUCLID, 3'(nd));
        1: setup($urandom_range(1, 4000), $urandom_range(1, 5), MEAS_RMS, 3'(nd));
        default: setup($urandom_range(1, 150), $urandom_range(1, 5), MEAS_MANHATTAN, 3'(nd));
      endcase
      send_set($urandom_range(2, 12), nd, 40, 1);
    end
    settle();
    $display("coverage: %0d coordinate words in %0d point sets, %0d labels checked",
             words, sets, results);
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
